@@ rtl/rcfu_pkg.sv @@
`default_nettype none
package rcfu_pkg;

   localparam int NUM_CHANNELS_DEF = 16;
   localparam int CHANNEL_BITS_DEF = 11;

   localparam int BYTE_W      = 8;
   localparam int VALUE_W     = 11;
   localparam int INDEX_W     = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int HEADER_BYTES = 3;

   localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hC8;
   localparam logic [BYTE_W-1:0] TYPE_RESET = 8'h16;

   localparam logic [CSR_IDX_W-1:0] CSR_SYNC = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TYPE = 2'd1;

   // Framer to unpacker: byte taken this cycle, and whether it is payload
   typedef struct packed {
      logic              accept;
      logic              payload;
      logic [BYTE_W-1:0] data;
   } ctrl_type;

   typedef struct packed {
      logic               emit;
      logic [VALUE_W-1:0] value;
      logic [INDEX_W-1:0] index;
      logic               last;
   } result_type;

endpackage
`default_nettype wire

@@ rtl/rcfu_framer.sv @@
`default_nettype none
module rcfu_framer #(
   parameter int NUM_CHANNELS = rcfu_pkg::NUM_CHANNELS_DEF,
   parameter int CHANNEL_BITS = rcfu_pkg::CHANNEL_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [rcfu_pkg::BYTE_W-1:0]   rx_byte,
   input  wire logic [rcfu_pkg::BYTE_W-1:0]   sync_value,
   input  wire logic [rcfu_pkg::BYTE_W-1:0]   type_value,
   output rcfu_pkg::ctrl_type                 ctrl
);

   localparam int PAYLOAD_BYTES = (NUM_CHANNELS * CHANNEL_BITS + 7) / 8;
   localparam int CNT_W = $clog2(PAYLOAD_BYTES + 1);

   typedef enum logic [3:0] {
      ST_HUNT = 4'b0001,
      ST_LEN  = 4'b0010,
      ST_TYPE = 4'b0100,
      ST_BODY = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             payload;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      payload  = 1'b0;
      unique case (state_ff)
         ST_HUNT: begin
            if (rx_byte == sync_value) state_in = ST_LEN;
         end
         ST_LEN: begin
            state_in = ST_TYPE;
         end
         ST_TYPE: begin
            // type match wins over a restart on sync
            if (rx_byte == type_value) begin
               state_in = ST_BODY;
               count_in = '0;
            end else if (rx_byte == sync_value) begin
               state_in = ST_LEN;
            end else begin
               state_in = ST_HUNT;
            end
         end
         ST_BODY: begin
            if (count_ff == CNT_W'(PAYLOAD_BYTES)) begin
               // trailing check byte: drop it and hunt again
               state_in = ST_HUNT;
            end else begin
               payload  = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
         count_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   assign ctrl = '{accept: accept, payload: payload, data: rx_byte};

endmodule
`default_nettype wire

@@ rtl/rcfu_unpacker.sv @@
`default_nettype none
module rcfu_unpacker #(
   parameter int NUM_CHANNELS = rcfu_pkg::NUM_CHANNELS_DEF,
   parameter int CHANNEL_BITS = rcfu_pkg::CHANNEL_BITS_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire rcfu_pkg::ctrl_type ctrl,
   output rcfu_pkg::result_type result
);

   // at most CHANNEL_BITS-1 bits remain after an emit, plus one byte
   localparam int ACC_W  = CHANNEL_BITS + rcfu_pkg::BYTE_W - 1;
   localparam int HELD_W = $clog2(ACC_W + 1);
   localparam int WIDE_W = (CHANNEL_BITS > rcfu_pkg::VALUE_W) ?
                           CHANNEL_BITS : rcfu_pkg::VALUE_W;
   localparam int IDX_W  = rcfu_pkg::INDEX_W;

   logic [ACC_W-1:0]  acc_ff, acc_in, acc_sum;
   logic [HELD_W-1:0] held_ff, held_in, held_sum;
   logic [IDX_W-1:0]  chan_ff, chan_in;
   logic [WIDE_W-1:0] value_wide;
   logic              emit, last;

   always_comb begin
      acc_sum    = acc_ff | (ACC_W'(ctrl.data) << held_ff);
      held_sum   = held_ff + HELD_W'(rcfu_pkg::BYTE_W);
      emit       = ctrl.payload && (held_sum >= HELD_W'(CHANNEL_BITS));
      last       = (chan_ff == IDX_W'(NUM_CHANNELS - 1));
      value_wide = WIDE_W'(acc_sum[CHANNEL_BITS-1:0]);

      acc_in  = acc_ff;
      held_in = held_ff;
      chan_in = chan_ff;
      if (!ctrl.payload) begin
         // anything but payload leaves the unpacker empty
         acc_in  = '0;
         held_in = '0;
         chan_in = '0;
      end else if (emit) begin
         acc_in  = acc_sum >> CHANNEL_BITS;
         held_in = held_sum - HELD_W'(CHANNEL_BITS);
         chan_in = last ? '0 : chan_ff + IDX_W'(1);
      end else begin
         acc_in  = acc_sum;
         held_in = held_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         held_ff <= '0;
         chan_ff <= '0;
      end else if (ctrl.accept) begin
         acc_ff  <= acc_in;
         held_ff <= held_in;
         chan_ff <= chan_in;
      end
   end

   assign result = '{emit:  ctrl.accept && emit,
                     value: value_wide[rcfu_pkg::VALUE_W-1:0],
                     index: chan_ff,
                     last:  last};

endmodule
`default_nettype wire

@@ rtl/rcfu_out_reg.sv @@
`default_nettype none
module rcfu_out_reg (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire rcfu_pkg::result_type           result,
   output logic                                free,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [rcfu_pkg::VALUE_W-1:0]        rsp_channel_value,
   output logic [rcfu_pkg::INDEX_W-1:0]        rsp_channel_index,
   output logic                                rsp_last_channel
);

   logic                         valid_ff;
   logic [rcfu_pkg::VALUE_W-1:0] value_ff;
   logic [rcfu_pkg::INDEX_W-1:0] index_ff;
   logic                         last_ff;

   // slot can take a new item when empty or draining this cycle
   assign free = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (free) begin
         valid_ff <= result.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (free && result.emit) begin
         value_ff <= result.value;
         index_ff <= result.index;
         last_ff  <= result.last;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_channel_value = value_ff;
   assign rsp_channel_index = index_ff;
   assign rsp_last_channel  = last_ff;

endmodule
`default_nettype wire

@@ rtl/rc_frame_channel_unpacker.sv @@
// Packed RC channel frame unpacker.
// req_ channel: one received byte per item (req_rx_byte), valid/ready.
// rsp_ channel: one unpacked channel per item (value, index, last flag).
// csr_ port: csr_we writes csr_wdata into the register at csr_index
//   (sync byte, frame type byte); write only while the block is idle.
// A byte that completes a channel puts that channel in the output
// register at the same edge that accepts the byte, so the result shows
// in the cycle after the byte is accepted. Throughput is one byte per
// cycle while the output register is free, set by the combinational
// shift/extract path between the accumulator and the output register.
// The byte following sync is skipped, the type byte is checked, then the
// payload bytes are unpacked LSB first; the final check byte is dropped.
// When the receiver stalls, the held result stays put and req_ready stays
// high only while that result is being taken this cycle.
// Reset (synchronous) returns to hunting, empties the output register and
// restores the default sync and type values.
`default_nettype none
module rc_frame_channel_unpacker #(
   parameter int NUM_CHANNELS = rcfu_pkg::NUM_CHANNELS_DEF,
   parameter int CHANNEL_BITS = rcfu_pkg::CHANNEL_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [rcfu_pkg::BYTE_W-1:0]      req_rx_byte,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [rcfu_pkg::VALUE_W-1:0]          rsp_channel_value,
   output logic [rcfu_pkg::INDEX_W-1:0]          rsp_channel_index,
   output logic                                  rsp_last_channel,
   input  wire logic                             csr_we,
   input  wire logic [rcfu_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [rcfu_pkg::BYTE_W-1:0]      csr_wdata
);

   logic [rcfu_pkg::BYTE_W-1:0] sync_ff, type_ff;
   logic                        free, accept;
   rcfu_pkg::ctrl_type          ctrl;
   rcfu_pkg::result_type        result;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= rcfu_pkg::SYNC_RESET;
         type_ff <= rcfu_pkg::TYPE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            rcfu_pkg::CSR_SYNC: sync_ff <= csr_wdata;
            rcfu_pkg::CSR_TYPE: type_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_ready = free;
   assign accept    = req_valid && free;

   rcfu_framer #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_framer (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .rx_byte    (req_rx_byte),
      .sync_value (sync_ff),
      .type_value (type_ff),
      .ctrl       (ctrl)
   );

   rcfu_unpacker #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_unpacker (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .result (result)
   );

   rcfu_out_reg u_out_reg (
      .clock             (clock),
      .reset             (reset),
      .result            (result),
      .free              (free),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_channel_value (rsp_channel_value),
      .rsp_channel_index (rsp_channel_index),
      .rsp_last_channel  (rsp_last_channel)
   );

endmodule
`default_nettype wire

@@ rtl/rcfu_checker.sv @@
`default_nettype none
module rcfu_checker #(
   parameter int NUM_CHANNELS = rcfu_pkg::NUM_CHANNELS_DEF
) (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_ready,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [rcfu_pkg::VALUE_W-1:0]   rsp_channel_value,
   input wire logic [rcfu_pkg::INDEX_W-1:0]   rsp_channel_index,
   input wire logic                           rsp_last_channel
);

   // the output register is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // an empty or draining output slot always takes a byte
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("input stalled with a free output slot");

   // last flag marks exactly the final channel index
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_channel ==
                     (rsp_channel_index == rcfu_pkg::INDEX_W'(NUM_CHANNELS - 1))))
      else $error("last flag does not match channel index");

   // a stalled result holds its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_channel_value) && $stable(rsp_channel_index)
          && $stable(rsp_last_channel)))
      else $error("stalled result changed");

endmodule

bind rc_frame_channel_unpacker rcfu_checker #(
   .NUM_CHANNELS (NUM_CHANNELS)
) u_rcfu_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_channel_value (rsp_channel_value),
   .rsp_channel_index (rsp_channel_index),
   .rsp_last_channel  (rsp_last_channel)
);
`default_nettype wire

@@ dv/tb_rc_frame_channel_unpacker.sv @@
`default_nettype none
module tb_rc_frame_channel_unpacker;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_CH        = rcfu_pkg::NUM_CHANNELS_DEF;
   localparam int CH_BITS       = rcfu_pkg::CHANNEL_BITS_DEF;
   localparam int PAYLOAD_BYTES = (NUM_CH * CH_BITS + 7) / 8;
   localparam int SETTLE_CYCLES = 4;
   localparam int HOLD_CYCLES   = 60;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_BYTES   = 175;

   localparam logic [rcfu_pkg::CSR_IDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [rcfu_pkg::CSR_IDX_W-1:0] CSR_SPARE_3 = 2'd3;

   // payload content styles
   localparam int BODY_RANDOM = 0;
   localparam int BODY_ZEROS  = 1;
   localparam int BODY_ONES   = 2;
   localparam int BODY_MARKED = 3;

   typedef struct {
      logic [rcfu_pkg::VALUE_W-1:0] value;
      logic [rcfu_pkg::INDEX_W-1:0] index;
      logic                         last;
   } chan_item_type;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic [rcfu_pkg::BYTE_W-1:0]    req_rx_byte;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [rcfu_pkg::VALUE_W-1:0]   rsp_channel_value;
   logic [rcfu_pkg::INDEX_W-1:0]   rsp_channel_index;
   logic                           rsp_last_channel;
   logic                           csr_we;
   logic [rcfu_pkg::CSR_IDX_W-1:0] csr_index;
   logic [rcfu_pkg::BYTE_W-1:0]    csr_wdata;

   chan_item_type channel_q[$];

   // predictor state
   logic [rcfu_pkg::BYTE_W-1:0] sync_reg;
   logic [rcfu_pkg::BYTE_W-1:0] type_reg;
   bit                in_frame;
   int                frame_pos;
   int unsigned       acc_bits;
   int                acc_count;
   int                next_index;

   bit idle_enable;
   bit sink_hold_req;
   int sink_hold_count;
   int sink_stall_left;
   int bytes_sent;
   int fail_count;
   int shown_count;
   int cycle_count;

   rc_frame_channel_unpacker i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_channel_value (rsp_channel_value),
      .rsp_channel_index (rsp_channel_index),
      .rsp_last_channel  (rsp_last_channel),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void clear_accumulator();
      acc_bits   = 0;
      acc_count  = 0;
      next_index = 0;
   endfunction

   function automatic void hunt_sync();
      in_frame  = 1'b0;
      frame_pos = 0;
      clear_accumulator();
   endfunction

   // Advance the frame state by one byte and queue any channel it completes.
   function automatic void unpack_byte(input logic [rcfu_pkg::BYTE_W-1:0] b);
      chan_item_type c;
      if (!in_frame) begin
         if (b == sync_reg) begin
            in_frame  = 1'b1;
            frame_pos = 1;
            clear_accumulator();
         end
         return;
      end
      if (frame_pos == 1) begin
         frame_pos = 2;
         return;
      end
      if (frame_pos == 2) begin
         // type match wins over a restart when both registers hold the same value
         if (b == type_reg) begin
            frame_pos = rcfu_pkg::HEADER_BYTES;
            clear_accumulator();
         end else if (b == sync_reg) begin
            frame_pos = 1;
            clear_accumulator();
         end else begin
            hunt_sync();
         end
         return;
      end
      if (frame_pos >= rcfu_pkg::HEADER_BYTES + PAYLOAD_BYTES) begin
         hunt_sync();
         return;
      end
      frame_pos++;
      acc_bits  = acc_bits | (32'(b) << acc_count);
      acc_count = acc_count + 8;
      if (acc_count >= CH_BITS) begin
         c.value = acc_bits[rcfu_pkg::VALUE_W-1:0];
         c.index = next_index[rcfu_pkg::INDEX_W-1:0];
         c.last  = (next_index == NUM_CH - 1);
         channel_q.push_back(c);
         acc_bits   = acc_bits >> CH_BITS;
         acc_count  = acc_count - CH_BITS;
         next_index = c.last ? 0 : next_index + 1;
      end
   endfunction

   task automatic note_failure(input string msg);
      fail_count++;
      if (shown_count < 10) begin
         shown_count++;
         $display("%0t: %s", $realtime, msg);
      end
   endtask

   always @(posedge clock) begin
      chan_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (channel_q.size() == 0) begin
            note_failure($sformatf("unexpected channel value=%0d index=%0d last=%0b",
               rsp_channel_value, rsp_channel_index, rsp_last_channel));
         end else begin
            want = channel_q.pop_front();
            if (rsp_channel_value !== want.value || rsp_channel_index !== want.index ||
                rsp_last_channel !== want.last) begin
               note_failure($sformatf({"channel mismatch: expected value=%0d ",
                  "index=%0d last=%0b, got value=%0d index=%0d last=%0b"},
                  want.value, want.index, want.last,
                  rsp_channel_value, rsp_channel_index, rsp_last_channel));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("rc_frame_channel_unpacker verification failed");
         $finish;
      end
   end

   // Result side: long hold on request, otherwise short random stalls while idle_enable is set.
   initial begin
      rsp_ready       = 1'b0;
      sink_stall_left = 0;
      sink_hold_count = 0;
      forever begin
         @(negedge clock);
         if (sink_hold_req) begin
            rsp_ready <= 1'b0;
            sink_hold_count++;
            if (sink_hold_count >= HOLD_CYCLES) begin
               sink_hold_req   = 1'b0;
               sink_hold_count = 0;
            end
         end else if (sink_stall_left > 0) begin
            rsp_ready <= 1'b0;
            sink_stall_left--;
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            sink_stall_left = $urandom_range(0, 2);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_byte(input logic [rcfu_pkg::BYTE_W-1:0] b);
      @(negedge clock);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      unpack_byte(b);
      bytes_sent++;
   endtask

   // Drop valid, wait for all channels to arrive, then let the pipeline settle.
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (channel_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [rcfu_pkg::CSR_IDX_W-1:0] idx,
                            input logic [rcfu_pkg::BYTE_W-1:0] data);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == rcfu_pkg::CSR_SYNC)
         sync_reg = data;
      else if (idx == rcfu_pkg::CSR_TYPE)
         type_reg = data;
   endtask

   // Payload bytes followed by the check byte.
   task automatic send_body(input int mode);
      int i;
      logic [rcfu_pkg::BYTE_W-1:0] b;
      for (i = 0; i <= PAYLOAD_BYTES; i++) begin
         case (mode)
            BODY_ZEROS: b = 8'h00;
            BODY_ONES:  b = 8'hFF;
            BODY_MARKED: begin
               case ($urandom_range(0, 4))
                  0: b = sync_reg;
                  1: b = type_reg;
                  2: b = 8'h00;
                  3: b = 8'hFF;
                  default: b = 8'($urandom);
               endcase
            end
            default: b = 8'($urandom);
         endcase
         send_byte(b);
      end
   endtask

   task automatic send_frame(input int mode);
      send_byte(sync_reg);
      send_byte(8'($urandom));
      send_byte(type_reg);
      send_body(mode);
   endtask

   task automatic send_random_frame();
      int kind;
      int i;
      logic [rcfu_pkg::BYTE_W-1:0] b;
      kind = $urandom_range(0, 15);
      if (kind < 11) begin
         send_frame($urandom_range(0, 9) < 7 ? BODY_RANDOM : $urandom_range(1, 3));
      end else if (kind < 13) begin
         send_byte(sync_reg);
         send_byte(8'($urandom));
         b = 8'($urandom);
         if (b == type_reg)
            b = ~type_reg;
         send_byte(b);
      end else if (kind == 13) begin
         send_byte(sync_reg);
         send_byte(8'($urandom));
         send_frame(BODY_RANDOM);
      end else if (kind == 14) begin
         // cut the frame short; the next header lands inside its payload
         send_byte(sync_reg);
         send_byte(8'($urandom));
         send_byte(type_reg);
         repeat ($urandom_range(1, PAYLOAD_BYTES - 1)) send_byte(8'($urandom));
      end else begin
         for (i = 0; i < $urandom_range(1, 6); i++) send_byte(8'($urandom));
      end
   endtask

   task automatic test_default_frame();
      int i;
      send_byte(sync_reg);
      send_byte(8'h18);
      send_byte(type_reg);
      for (i = 0; i < PAYLOAD_BYTES; i++)
         send_byte(i < 11 ? 8'hFF : (i == PAYLOAD_BYTES - 1 ? sync_reg : 8'h00));
      send_byte(sync_reg);
      send_frame(BODY_ZEROS);
      send_frame(BODY_ONES);
   endtask

   task automatic test_header_faults();
      send_byte(sync_reg);
      send_byte(8'h18);
      send_byte(8'h55);
      // a plain type byte while hunting must be ignored
      send_byte(type_reg);
      send_byte(sync_reg);
      send_byte(8'h18);
      send_byte(sync_reg);
      send_byte(8'h18);
      send_byte(type_reg);
      send_body(BODY_MARKED);
   endtask

   task automatic test_sync_equals_type();
      write_reg(rcfu_pkg::CSR_SYNC, 8'h5A);
      write_reg(rcfu_pkg::CSR_TYPE, 8'h5A);
      send_frame(BODY_MARKED);
   endtask

   task automatic test_spare_index();
      write_reg(CSR_SPARE_2, 8'h00);
      write_reg(CSR_SPARE_3, 8'hFF);
      send_frame(BODY_RANDOM);
   endtask

   task automatic test_register_extremes();
      write_reg(rcfu_pkg::CSR_SYNC, 8'h00);
      write_reg(rcfu_pkg::CSR_TYPE, 8'hFF);
      send_frame(BODY_MARKED);
      write_reg(rcfu_pkg::CSR_SYNC, 8'hFF);
      write_reg(rcfu_pkg::CSR_TYPE, 8'h00);
      send_frame(BODY_MARKED);
      write_reg(rcfu_pkg::CSR_SYNC, rcfu_pkg::SYNC_RESET);
      write_reg(rcfu_pkg::CSR_TYPE, rcfu_pkg::TYPE_RESET);
   endtask

   task automatic test_backpressure();
      idle_enable   = 1'b0;
      sink_hold_req = 1'b1;
      send_frame(BODY_RANDOM);
      send_frame(BODY_RANDOM);
      idle_enable = 1'b1;
      wait_idle();
   endtask

   task automatic test_random_traffic();
      int phase;
      int target;
      logic [rcfu_pkg::BYTE_W-1:0] s;
      logic [rcfu_pkg::BYTE_W-1:0] t;
      for (phase = 0; phase < 8; phase++) begin
         s = 8'($urandom);
         t = 8'($urandom);
         case (phase)
            0: begin s = rcfu_pkg::SYNC_RESET; t = rcfu_pkg::TYPE_RESET; end
            1: begin s = 8'h00; t = 8'hFF; end
            2: begin s = 8'hFF; t = 8'h00; end
            3: t = s;
            default: ;
         endcase
         write_reg(rcfu_pkg::CSR_SYNC, s);
         write_reg(rcfu_pkg::CSR_TYPE, t);
         if (phase == 7)
            idle_enable = 1'b0;
         target = bytes_sent + PHASE_BYTES;
         while (bytes_sent < target) send_random_frame();
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_rx_byte   = '0;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      idle_enable   = 1'b1;
      sink_hold_req = 1'b0;
      bytes_sent    = 0;
      fail_count    = 0;
      shown_count   = 0;
      cycle_count   = 0;
      sync_reg      = rcfu_pkg::SYNC_RESET;
      type_reg      = rcfu_pkg::TYPE_RESET;
      hunt_sync();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_frame();
      test_header_faults();
      test_sync_equals_type();
      test_spare_index();
      test_register_extremes();
      test_backpressure();
      test_random_traffic();

      wait_idle();
      if (fail_count == 0)
         $display("rc_frame_channel_unpacker verification clean");
      else
         $display("rc_frame_channel_unpacker verification failed");
      $finish;
   end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/rcfu_pkg.sv
rtl/rcfu_framer.sv
rtl/rcfu_unpacker.sv
rtl/rcfu_out_reg.sv
rtl/rc_frame_channel_unpacker.sv
rtl/rcfu_checker.sv
dv/tb_rc_frame_channel_unpacker.sv
